[src/plid_pkg.sv]
// Package: shared constants, codes and control types for the positional list unit.
`timescale 1ns / 1ps

package plid_pkg;

  localparam int CAPACITY = 16;

  localparam int IDX_W   = (CAPACITY > 2) ? $clog2(CAPACITY) : 1;
  localparam int CNT_W   = $clog2(CAPACITY + 1);
  localparam int POS_W   = 5;
  localparam int VAL_W   = 32;
  localparam int ACT_W   = 2;
  localparam int OCNT_W  = 5;
  localparam int CMP_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
  localparam int TDATA_W = 40;

  localparam logic [ACT_W-1:0] ACT_INSERT = 2'd0;
  localparam logic [ACT_W-1:0] ACT_DELETE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ   = 2'd2;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2,
    ST_EMPTY  = 2'd3
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;
    logic execute;
  } plid_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_free;
  } plid_sts_t;

endpackage

[src/plid_ctrl.sv]
// Controller: takes a request, then runs it once the result register is free.
`timescale 1ns / 1ps

module plid_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  plid_pkg::plid_sts_t sts,
  output plid_pkg::plid_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   in_tready_r, in_tready_nxt;

  always_comb begin
    state_nxt     = state_r;
    in_tready_nxt = in_tready_r;
    cmd.load_req  = 1'b0;
    cmd.execute   = 1'b0;
    case (state_r)
      S_IDLE: begin
        // Ready stays low through reset and is set again once reset is released.
        in_tready_nxt = 1'b1;
        if (in_tvalid && in_tready_r) begin
          cmd.load_req  = 1'b1;
          state_nxt     = S_EXEC;
          in_tready_nxt = 1'b0;
        end
      end
      S_EXEC: begin
        // The request waits here while an earlier result is still unclaimed.
        if (sts.out_free) begin
          cmd.execute   = 1'b1;
          state_nxt     = S_IDLE;
          in_tready_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt     = S_IDLE;
        in_tready_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      in_tready_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_tready_r <= in_tready_nxt;
    end
  end

  assign in_tready = in_tready_r;

endmodule

[src/plid_dp.sv]
// Datapath: request register, entry shift chain, count and result register.
`timescale 1ns / 1ps

module plid_dp (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic [plid_pkg::TDATA_W-1:0]       in_tdata,
  input  logic                               in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [plid_pkg::TDATA_W-1:0]       out_tdata,
  input  plid_pkg::plid_cmd_t                cmd,
  output plid_pkg::plid_sts_t                sts
);

  logic [plid_pkg::ACT_W-1:0]  act_r;
  logic [plid_pkg::VAL_W-1:0]  val_r;
  logic [plid_pkg::POS_W-1:0]  pos_r;
  logic                        end_r;

  logic [plid_pkg::VAL_W-1:0]  entries_r [plid_pkg::CAPACITY];
  logic [plid_pkg::CNT_W-1:0]  count_r, count_nxt;

  logic                        out_valid_r, out_valid_nxt;
  plid_pkg::status_t           out_status_r;
  logic [plid_pkg::VAL_W-1:0]  out_value_r;
  logic [plid_pkg::OCNT_W-1:0] out_count_r;

  logic [plid_pkg::CMP_W-1:0]  n_ext, ep;
  logic [plid_pkg::IDX_W-1:0]  idx;
  plid_pkg::status_t           status;
  logic                        do_ins, do_del;
  logic [plid_pkg::VAL_W-1:0]  rd_val;

  always_ff @(posedge clk) begin
    if (cmd.load_req) begin
      act_r <= in_tdata[1:0];
      val_r <= in_tdata[33:2];
      pos_r <= in_tdata[38:34];
      end_r <= in_tuser;
    end
  end

  always_comb begin
    n_ext  = plid_pkg::CMP_W'(count_r);
    ep     = plid_pkg::CMP_W'(pos_r);
    status = plid_pkg::ST_BADPOS;
    do_ins = 1'b0;
    do_del = 1'b0;
    case (act_r)
      plid_pkg::ACT_INSERT: begin
        if (count_r == plid_pkg::CNT_W'(plid_pkg::CAPACITY)) begin
          status = plid_pkg::ST_FULL;
        end else begin
          if (end_r) ep = n_ext + 1'b1;
          if (ep != '0 && ep <= n_ext + 1'b1) begin
            status = plid_pkg::ST_OK;
            do_ins = 1'b1;
          end
        end
      end
      plid_pkg::ACT_DELETE, plid_pkg::ACT_READ: begin
        if (count_r == '0) begin
          status = plid_pkg::ST_EMPTY;
        end else begin
          if (end_r) ep = n_ext;
          if (ep != '0 && ep <= n_ext) begin
            status = plid_pkg::ST_OK;
            do_del = (act_r == plid_pkg::ACT_DELETE);
          end
        end
      end
      default: status = plid_pkg::ST_BADPOS;
    endcase
    idx = plid_pkg::IDX_W'(ep - 1'b1);
  end

  // Only a request that passed its checks reads, so the index is in range here.
  assign rd_val = (status == plid_pkg::ST_OK && act_r != plid_pkg::ACT_INSERT)
                  ? entries_r[idx] : '0;

  always_comb begin
    count_nxt = count_r;
    if (do_ins) count_nxt = count_r + 1'b1;
    else if (do_del) count_nxt = count_r - 1'b1;
  end

  // Every entry loads from its own neighbour, so all entries shift at once.
  for (genvar g = 0; g < plid_pkg::CAPACITY; g++) begin : g_entry
    always_ff @(posedge clk) begin
      if (cmd.execute) begin
        if (do_ins) begin
          if (plid_pkg::IDX_W'(g) == idx) begin
            entries_r[g] <= val_r;
          end else if (plid_pkg::IDX_W'(g) > idx) begin
            if (g > 0) entries_r[g] <= entries_r[(g > 0) ? g - 1 : 0];
          end
        end else if (do_del) begin
          if (plid_pkg::IDX_W'(g) >= idx && g < plid_pkg::CAPACITY - 1) begin
            entries_r[g] <= entries_r[(g < plid_pkg::CAPACITY - 1) ? g + 1 : g];
          end
        end
      end
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.execute) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (cmd.execute) count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute) begin
      out_status_r <= status;
      out_value_r  <= rd_val;
      out_count_r  <= plid_pkg::OCNT_W'(count_nxt);
    end
  end

  assign sts.out_free = !out_valid_r || out_tready;
  assign out_tvalid   = out_valid_r;
  assign out_tdata    = {1'b0, out_count_r, out_value_r, out_status_r};

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= plid_pkg::CNT_W'(plid_pkg::CAPACITY))
    else $error("entry count above capacity");

  a_exec_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_valid_r)
    else $error("executed request left no result");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.execute && do_ins) |=> count_r == $past(count_r) + 1'b1)
    else $error("insert did not raise the count");
`endif

endmodule

[src/positional_list_insert_delete_unit.sv]
// Top level: positional list with insert, delete and read at a 1-based position.
`timescale 1ns / 1ps
//
// The block holds an ordered list of up to plid_pkg::CAPACITY signed 32-bit
// values. A request on the in_ channel inserts, deletes or reads at a
// position, or at the end when in_tuser (to_end) is set. Each request gives
// exactly one result on the out_ channel: a status, the value read or
// deleted, and the entry count after the request. A failed request leaves
// the list untouched.
// A request is first registered, then, once the result register is free,
// checked, and in the same step the entry chain is shifted and the result
// register loaded. The shift chain moves every entry at once, so this does
// not depend on position. A new request is taken only once the last has run.
// While a result waits in the output register the next request is still
// taken, and held until the receiver frees the result register.
// Reset empties the list and clears both channels; no clearing pass is run.
//
module positional_list_insert_delete_unit (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // fields from bit 0: action[1:0], new_value[33:2], position[38:34]
  input  logic [plid_pkg::TDATA_W-1:0] in_tdata,
  // fields from bit 0: to_end[0]
  input  logic                         in_tuser,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  // fields from bit 0: status[1:0], read_value[33:2], entry_count[38:34]
  output logic [plid_pkg::TDATA_W-1:0] out_tdata
);

  plid_pkg::plid_cmd_t cmd;
  plid_pkg::plid_sts_t sts;

  plid_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  plid_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cmd        (cmd),
    .sts        (sts)
  );

endmodule

[tb/sv/tb_positional_list_insert_delete_unit.sv]
// Testbench for the positional list unit: directed and random requests checked against a list mirror.
`timescale 1ns / 1ps

module tb_positional_list_insert_delete_unit;
  import plid_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_ITEMS = 340;
  localparam int REPORT_MAX  = 10;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  logic               clk;
  logic               rst_n;
  logic               in_tvalid;
  logic               in_tready;
  logic [TDATA_W-1:0] in_tdata;
  logic               in_tuser;
  logic               out_tvalid;
  logic               out_tready;
  logic [TDATA_W-1:0] out_tdata;

  int   tx_idle_pct;
  int   rx_idle_pct;
  logic hold_off_req;
  int   cycles;

  typedef struct {
    status_t           status;
    logic [VAL_W-1:0]  value;
    logic [OCNT_W-1:0] count;
  } list_reply_t;

  // Mirrors the list contents and queues the reply each accepted request should produce.
  class list_scoreboard;
    logic [VAL_W-1:0] entries [CAPACITY];
    int               length;
    list_reply_t      pending_replies [$];
    int               mismatches;

    function new();
      length     = 0;
      mismatches = 0;
    endfunction

    function void note_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] val,
                               logic [POS_W-1:0] pos, logic to_end);
      list_reply_t r;
      int          p;
      int          i;
      r.status = ST_OK;
      r.value  = '0;
      if (act == ACT_INSERT) begin
        p = to_end ? length + 1 : int'(pos);
        if (length >= CAPACITY) begin
          r.status = ST_FULL;
        end else if (p < 1 || p > length + 1) begin
          r.status = ST_BADPOS;
        end else begin
          for (i = length; i > p - 1; i--) entries[i] = entries[i-1];
          entries[p-1] = val;
          length++;
        end
      end else if (act == ACT_DELETE || act == ACT_READ) begin
        p = to_end ? length : int'(pos);
        if (length == 0) begin
          r.status = ST_EMPTY;
        end else if (p < 1 || p > length) begin
          r.status = ST_BADPOS;
        end else begin
          r.value = entries[p-1];
          if (act == ACT_DELETE) begin
            for (i = p - 1; i + 1 < length; i++) entries[i] = entries[i+1];
            length--;
          end
        end
      end else begin
        r.status = ST_BADPOS;
      end
      r.count = OCNT_W'(length);
      pending_replies.push_back(r);
    endfunction

    function void check_result(logic [TDATA_W-1:0] word);
      list_reply_t       want;
      logic [1:0]        got_status;
      logic [VAL_W-1:0]  got_value;
      logic [OCNT_W-1:0] got_count;
      got_status = word[1:0];
      got_value  = word[33:2];
      got_count  = word[38:34];
      if (pending_replies.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_MAX)
          $display("%0t: result with no request outstanding: status %0d value %h count %0d",
                   $time, got_status, got_value, got_count);
      end else begin
        want = pending_replies.pop_front();
        if (got_status !== want.status || got_value !== want.value ||
            got_count !== want.count) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: expected status %0d value %h count %0d, got status %0d value %h count %0d",
                     $time, want.status, want.value, want.count,
                     got_status, got_value, got_count);
        end
      end
    endfunction
  endclass

  list_scoreboard board = new();

  positional_list_insert_delete_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // A result and a new request can meet at one edge; the result always belongs to an older request.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_tvalid && out_tready) board.check_result(out_tdata);
      if (in_tvalid && in_tready)
        board.note_request(in_tdata[1:0], in_tdata[33:2], in_tdata[38:34], in_tuser);
    end
  end

  // Result side: random back-pressure, or a long hold-off when one is asked for.
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (hold_off_req) begin
        hold_left    = HOLD_CYCLES;
        hold_off_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  initial begin
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic send_request(input logic [ACT_W-1:0] act, input logic [VAL_W-1:0] val,
                              input logic [POS_W-1:0] pos, input logic to_end);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {1'b0, pos, val, act};
    in_tuser  <= to_end;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  task automatic send_random(input int insert_pct);
    logic [ACT_W-1:0] act;
    logic [POS_W-1:0] pos;
    int               roll;
    roll = $urandom_range(99);
    if (roll < 3)
      act = ACT_UNUSED;
    else if (roll < insert_pct)
      act = ACT_INSERT;
    else if (roll < insert_pct + (100 - insert_pct) / 2)
      act = ACT_DELETE;
    else
      act = ACT_READ;
    // Mostly positions near the live range, now and then anywhere in the field.
    if ($urandom_range(9) == 0)
      pos = POS_W'($urandom_range(31));
    else
      pos = POS_W'($urandom_range(17));
    send_request(act, $urandom(), pos, $urandom_range(3) == 0);
  endtask

  task automatic run_random_phase();
    int n;
    for (n = 0; n < PHASE_ITEMS; n++)
      send_random(((n / 40) % 2 == 0) ? 75 : 25);
  endtask

  initial begin
    int               k;
    logic [VAL_W-1:0] fill_value;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tdata     = '0;
    in_tuser     = 1'b0;
    out_tready   = 1'b0;
    hold_off_req = 1'b0;
    tx_idle_pct  = 38;
    rx_idle_pct  = 70;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Empty list, bad insert positions and the unused action.
    send_request(ACT_READ, '0, 5'd1, 1'b0);
    send_request(ACT_DELETE, '1, 5'd0, 1'b1);
    send_request(ACT_INSERT, 32'h1234_5678, 5'd0, 1'b0);
    send_request(ACT_INSERT, 32'h1234_5678, 5'd2, 1'b0);
    send_request(ACT_UNUSED, '1, 5'd31, 1'b1);

    // Fill to capacity at the front, the end, the middle and one past the last entry.
    for (k = 0; k < CAPACITY; k++) begin
      case (k)
        0:       fill_value = 32'h8000_0000;
        1:       fill_value = 32'h7FFF_FFFF;
        2:       fill_value = '1;
        3:       fill_value = '0;
        default: fill_value = $urandom();
      endcase
      case (k % 4)
        0:       send_request(ACT_INSERT, fill_value, 5'd1, 1'b0);
        1:       send_request(ACT_INSERT, fill_value, 5'd31, 1'b1);
        2:       send_request(ACT_INSERT, fill_value, POS_W'(k / 2 + 1), 1'b0);
        default: send_request(ACT_INSERT, fill_value, POS_W'(k + 1), 1'b0);
      endcase
    end

    // Full list, bad read and delete positions, then reads at the end and deletes at both ends.
    send_request(ACT_INSERT, 32'h0BAD_F00D, 5'd1, 1'b0);
    send_request(ACT_READ, '0, 5'd31, 1'b0);
    send_request(ACT_READ, '0, 5'd0, 1'b0);
    send_request(ACT_READ, '0, 5'd16, 1'b0);
    send_request(ACT_READ, '0, 5'd0, 1'b1);
    send_request(ACT_DELETE, '0, 5'd17, 1'b0);
    send_request(ACT_DELETE, '0, 5'd1, 1'b0);
    send_request(ACT_DELETE, '0, 5'd31, 1'b1);

    run_random_phase();
    tx_idle_pct = 70;
    rx_idle_pct = 38;
    run_random_phase();
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // The sender keeps offering while results are held back, so the input must stall.
    hold_off_req = 1'b1;
    run_random_phase();

    in_tvalid <= 1'b0;
    // Let the monitor note the last request before the queue is inspected.
    @(posedge clk);
    while (board.pending_replies.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
    if (board.mismatches == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule

[filelist.f]
src/plid_pkg.sv
src/plid_ctrl.sv
src/plid_dp.sv
src/positional_list_insert_delete_unit.sv
tb/sv/tb_positional_list_insert_delete_unit.sv
